>>> rtl/core/grid_laplacian_stencil_unit_defines.svh
`ifndef GRID_LAPLACIAN_STENCIL_UNIT_DEFINES_SVH
`define GRID_LAPLACIAN_STENCIL_UNIT_DEFINES_SVH

// check while out of reset
`define GLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define GLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/gls_pkg.sv
`default_nettype none

package gls_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int FACTOR_W   = 32;
  localparam int CFG_W      = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;

  localparam int EDGE_W     = SAMPLE_W + 2;
  localparam int SUM_W      = SAMPLE_W + 6;
  localparam int MAG_W      = SUM_W - 1;
  localparam int LO_W       = 32;
  localparam int HI_W       = MAG_W - LO_W;
  localparam int P0_W       = LO_W + FACTOR_W;
  localparam int P1_W       = HI_W + FACTOR_W;
  localparam int PROD_W     = MAG_W + FACTOR_W;
  localparam int FRAC_SHIFT = 18;
  localparam int Q_W        = PROD_W - FRAC_SHIFT;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [SAMPLE_W-1:0] SAT_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic KMODE_NINE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_INV_H_SQ    = 2'd2,
    REG_KERNEL_MODE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    pos_t                pos;
    logic                sat;
  } res_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v < CFG_W'(3)) begin
      r = CFG_W'(3);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/grid_laplacian_stencil_unit.sv
// channel  dir  handshake            word
// in       in   in_valid/in_stall    in_sample
// out      out  out_valid/out_stall  out_laplacian_value, out_column, out_row, out_saturated
// cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One input word per cycle sustained while in_stall is low; a result reaches out_valid through
// the line buffer read beside stage 1, five kernel/scale stages and the queue write.
// in_stall rises only when 8 results are owed to the output queue.
// Reset (rst_n low, synchronous) clears counters and pipe valids; line buffers keep data.
// A grid_width or grid_height write restarts the frame at row 0, column 0.
`default_nettype none

module grid_laplacian_stencil_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gls_pkg::sample_t                 in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gls_pkg::sample_t                 out_laplacian_value,
  output logic [gls_pkg::COL_W-1:0]        out_column,
  output logic [gls_pkg::ROW_W-1:0]        out_row,
  output logic                             out_saturated,
  input  logic                             cfg_we,
  input  logic [gls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gls_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gls_pkg::*;

  logic [CFG_W-1:0]    width_r, height_r;
  logic [FACTOR_W-1:0] inv_h_sq_r;
  logic                kmode_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] col_inc, row_inc;
  logic             accept, emit;
  logic             size_wr;

  logic             s1_vld_r, s1_emit_r;
  pos_t             s1_pos_r;
  sample_t          s1_sample_r;
  logic [ADDR_W-1:0] s1_addr_r;
  pos_t             acc_pos;

  sample_t          rd_upper, rd_middle;

  logic                    sum_vld;
  pos_t                    sum_pos;
  logic signed [SUM_W-1:0] sum;
  logic                    res_vld;
  res_t                    res;
  res_t                    head;
  logic                    pop;
  logic [CNT_W-1:0]        cred_r;

  assign accept  = in_valid && !in_stall;
  assign pop     = out_valid && !out_stall;
  assign in_stall = cred_r == CNT_W'(FIFO_DEPTH);
  assign size_wr = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= CFG_W'(MAX_WIDTH);
      height_r   <= CFG_W'(MAX_HEIGHT);
      inv_h_sq_r <= FACTOR_W'(65536);
      kmode_r    <= KMODE_NINE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_WIDTH:  width_r    <= clamp_size(cfg_wdata[CFG_W-1:0], CFG_W'(MAX_WIDTH));
        REG_GRID_HEIGHT: height_r   <= clamp_size(cfg_wdata[CFG_W-1:0], CFG_W'(MAX_HEIGHT));
        REG_INV_H_SQ:    inv_h_sq_r <= cfg_wdata[FACTOR_W-1:0];
        REG_KERNEL_MODE: kmode_r    <= cfg_wdata[0];
        default:         kmode_r    <= kmode_r;
      endcase
    end
  end

  assign col_inc = CFG_W'(col_r) + CFG_W'(1);
  assign row_inc = CFG_W'(row_r) + CFG_W'(1);

  always_comb begin
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = row_r;
    if (col_inc >= width_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= height_r) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  assign emit        = col_r >= COL_W'(2) && row_r >= ROW_W'(2);
  assign acc_pos.col = col_r - COL_W'(1);
  assign acc_pos.row = row_r - ROW_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
      cred_r   <= '0;
    end else begin
      if (size_wr) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_vld_r <= accept;
      case ({accept && emit, pop})
        2'b10:   cred_r <= cred_r + CNT_W'(1);
        2'b01:   cred_r <= cred_r - CNT_W'(1);
        default: cred_r <= cred_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r   <= emit;
      s1_pos_r    <= acc_pos;
      s1_sample_r <= in_sample;
      s1_addr_r   <= col_r[ADDR_W-1:0];
    end
  end

  gls_line_buf u_line_buf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col_r[ADDR_W-1:0]),
    .wr_en     (s1_vld_r),
    .wr_addr   (s1_addr_r),
    .wr_upper  (rd_middle),
    .wr_middle (s1_sample_r),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  gls_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_vld      (s1_vld_r),
    .s1_emit     (s1_emit_r),
    .s1_pos      (s1_pos_r),
    .s1_sample   (s1_sample_r),
    .top         (rd_upper),
    .mid         (rd_middle),
    .kernel_mode (kmode_r),
    .sum_vld     (sum_vld),
    .sum_pos     (sum_pos),
    .sum         (sum)
  );

  gls_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .sum_vld (sum_vld),
    .sum_pos (sum_pos),
    .sum     (sum),
    .factor  (inv_h_sq_r),
    .res_vld (res_vld),
    .res     (res)
  );

  gls_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop       (pop),
    .out_vld   (out_valid),
    .out_data  (head)
  );

  assign out_laplacian_value = head.value;
  assign out_column          = head.pos.col;
  assign out_row             = head.pos.row;
  assign out_saturated       = head.sat;

endmodule

`default_nettype wire

>>> rtl/core/gls_line_buf.sv
`default_nettype none

module gls_line_buf (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [gls_pkg::ADDR_W-1:0] rd_addr,
  input  logic                    wr_en,
  input  logic [gls_pkg::ADDR_W-1:0] wr_addr,
  input  gls_pkg::sample_t        wr_upper,
  input  gls_pkg::sample_t        wr_middle,
  output gls_pkg::sample_t        rd_upper,
  output gls_pkg::sample_t        rd_middle
);
  import gls_pkg::*;

  sample_t upper_mem [MAX_WIDTH];
  sample_t middle_mem [MAX_WIDTH];
  sample_t rd_upper_r;
  sample_t rd_middle_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r  <= upper_mem[rd_addr];
      rd_middle_r <= middle_mem[rd_addr];
    end
  end

  assign rd_upper  = rd_upper_r;
  assign rd_middle = rd_middle_r;

endmodule

`default_nettype wire

>>> rtl/core/gls_window.sv
`default_nettype none

module gls_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_vld,
  input  logic                          s1_emit,
  input  gls_pkg::pos_t                 s1_pos,
  input  gls_pkg::sample_t              s1_sample,
  input  gls_pkg::sample_t              top,
  input  gls_pkg::sample_t              mid,
  input  logic                          kernel_mode,
  output logic                          sum_vld,
  output gls_pkg::pos_t                 sum_pos,
  output logic signed [gls_pkg::SUM_W-1:0] sum
);
  import gls_pkg::*;

  sample_t w0_r, w1_r, w2_r, w3_r, w4_r, w5_r;

  logic signed [EDGE_W-1:0] edges_nxt, diags_nxt;
  logic signed [EDGE_W-1:0] edges_r, diags_r;
  sample_t                  centre_r;
  logic                     s2_vld_r;
  pos_t                     s2_pos_r;

  logic signed [SUM_W-1:0] e_x, d_x, c_x, nine_sum, five_sum, sum_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic                    s3_vld_r;
  pos_t                    s3_pos_r;

  assign edges_nxt = EDGE_W'(w0_r) + EDGE_W'(w2_r) + EDGE_W'(w4_r) + EDGE_W'(mid);
  assign diags_nxt = EDGE_W'(w3_r) + EDGE_W'(w5_r) + EDGE_W'(top) + EDGE_W'(s1_sample);

  // shift the window one column
  always_ff @(posedge clk) begin
    if (s1_vld) begin
      w3_r     <= w0_r;
      w4_r     <= w1_r;
      w5_r     <= w2_r;
      w0_r     <= top;
      w1_r     <= mid;
      w2_r     <= s1_sample;
      edges_r  <= edges_nxt;
      diags_r  <= diags_nxt;
      centre_r <= w1_r;
      s2_pos_r <= s1_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld && s1_emit;
      s3_vld_r <= s2_vld_r;
    end
  end

  assign e_x      = SUM_W'(edges_r);
  assign d_x      = SUM_W'(diags_r);
  assign c_x      = SUM_W'(centre_r);
  assign nine_sum = (e_x <<< 1) + d_x - ((c_x <<< 3) + (c_x <<< 2));
  assign five_sum = (e_x <<< 2) - (c_x <<< 4);
  assign sum_nxt  = (kernel_mode == KMODE_NINE) ? nine_sum : five_sum;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      sum_r    <= sum_nxt;
      s3_pos_r <= s2_pos_r;
    end
  end

  assign sum_vld = s3_vld_r;
  assign sum_pos = s3_pos_r;
  assign sum     = sum_r;

endmodule

`default_nettype wire

>>> rtl/core/gls_scale.sv
`default_nettype none

module gls_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             sum_vld,
  input  gls_pkg::pos_t                    sum_pos,
  input  logic signed [gls_pkg::SUM_W-1:0] sum,
  input  logic [gls_pkg::FACTOR_W-1:0]     factor,
  output logic                             res_vld,
  output gls_pkg::res_t                    res
);
  import gls_pkg::*;

  logic [SUM_W-1:0] sum_u, abs_v;
  logic             neg_x;

  logic             s4_vld_r, s5_vld_r, s6_vld_r;
  logic             s4_neg_r, s5_neg_r, s6_neg_r;
  pos_t             s4_pos_r, s5_pos_r, s6_pos_r;
  logic [MAG_W-1:0] mag_r;
  logic [P0_W-1:0]  p0_r;
  logic [P1_W-1:0]  p1_r;
  logic [PROD_W-1:0] prod_r;

  logic [Q_W-1:0]      q;
  logic [Q_W-1:0]      limit;
  logic                sat;
  logic [SAMPLE_W-1:0] value;

  assign sum_u = sum;
  assign neg_x = sum_u[SUM_W-1];
  assign abs_v = neg_x ? (~sum_u + SUM_W'(1)) : sum_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= sum_vld;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_vld) begin
      s4_neg_r <= neg_x;
      s4_pos_r <= sum_pos;
      mag_r    <= abs_v[MAG_W-1:0];
    end
    if (s4_vld_r) begin
      s5_neg_r <= s4_neg_r;
      s5_pos_r <= s4_pos_r;
      p0_r     <= P0_W'(mag_r[LO_W-1:0]) * P0_W'(factor);
      p1_r     <= P1_W'(mag_r[MAG_W-1:LO_W]) * P1_W'(factor);
    end
    if (s5_vld_r) begin
      s6_neg_r <= s5_neg_r;
      s6_pos_r <= s5_pos_r;
      prod_r   <= PROD_W'(p0_r) + {p1_r, {LO_W{1'b0}}};
    end
  end

  assign q     = prod_r[PROD_W-1:FRAC_SHIFT];
  assign limit = s6_neg_r ? Q_W'(SAT_NEG) : Q_W'(SAT_POS);
  assign sat   = q > limit;

  always_comb begin
    if (sat) begin
      value = s6_neg_r ? SAT_NEG : SAT_POS;
    end else if (s6_neg_r) begin
      value = ~q[SAMPLE_W-1:0] + SAMPLE_W'(1);
    end else begin
      value = q[SAMPLE_W-1:0];
    end
  end

  assign res_vld   = s6_vld_r;
  assign res.value = value;
  assign res.pos   = s6_pos_r;
  assign res.sat   = sat;

endmodule

`default_nettype wire

>>> rtl/core/gls_out_fifo.sv
`default_nettype none

module gls_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gls_pkg::res_t push_data,
  input  logic          pop,
  output logic          out_vld,
  output gls_pkg::res_t out_data
);
  import gls_pkg::*;

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign out_vld  = cnt_r != '0;
  assign out_data = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

>>> rtl/core/gls_checker.sv
`default_nettype none

`include "grid_laplacian_stencil_unit_defines.svh"

module gls_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [gls_pkg::SAMPLE_W-1:0]   out_laplacian_value,
  input logic [gls_pkg::COL_W-1:0]      out_column,
  input logic [gls_pkg::ROW_W-1:0]      out_row,
  input logic                           out_saturated
);
  import gls_pkg::*;

  `GLS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

  `GLS_ASSERT(a_out_hold,
              out_valid && out_stall |=> out_valid && $stable(out_laplacian_value) &&
                                         $stable(out_column) && $stable(out_row),
              "stalled word changed")

  `GLS_ASSERT(a_interior, out_valid |-> out_column != '0 && out_row != '0, "boundary point emitted")

  `GLS_ASSERT(a_sat_value,
              out_valid && out_saturated |->
                out_laplacian_value == SAT_POS || out_laplacian_value == SAT_NEG,
              "saturated word not at a limit")

endmodule

bind grid_laplacian_stencil_unit gls_checker u_gls_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_laplacian_value (out_laplacian_value),
  .out_column          (out_column),
  .out_row             (out_row),
  .out_saturated       (out_saturated)
);

`default_nettype wire
